>>> design/ctd_pkg.sv
// Package for the command token decoder: token and keyword codes, limits,
// and the character helpers used by the per-byte decode logic.
// No dependencies.
`default_nettype none

package ctd_pkg;

    // Limits of the decoder.
    localparam int MAX_TOKENS  = 3;
    localparam int MSG_LENGTH  = 256;
    localparam int POS_W       = $clog2(MSG_LENGTH);
    localparam int TOK_CNT_W   = $clog2(MAX_TOKENS + 1);
    localparam int NUM_KW      = 3;
    localparam int CHAR_CNT_W  = 3;
    localparam int HEX_W       = 16;

    // Stream payload layout.
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    localparam logic [7:0] CHAR_END   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;

    typedef enum logic [1:0] {
        TOK_KEYWORD = 2'd0,
        TOK_NUMBER  = 2'd1,
        TOK_STRING  = 2'd2
    } token_type_t;

    typedef enum logic [1:0] {
        KW_LOAD  = 2'd0,
        KW_STORE = 2'd1,
        KW_RESET = 2'd2
    } kw_code_t;

    // Keyword spellings, first character in the top byte, padded with zeros.
    localparam logic [39:0] KW_LOAD_TEXT  = {"load", 8'h00};
    localparam logic [39:0] KW_STORE_TEXT = "store";
    localparam logic [39:0] KW_RESET_TEXT = "reset";

    function automatic logic [CHAR_CNT_W-1:0] kw_len(input kw_code_t k);
        case (k)
            KW_LOAD:  kw_len = 3'd4;
            KW_STORE: kw_len = 3'd5;
            KW_RESET: kw_len = 3'd5;
            default:  kw_len = 3'd0;
        endcase
    endfunction

    // True when character c at position p rules out keyword k.
    function automatic logic kw_mismatch(input kw_code_t k,
                                         input logic [CHAR_CNT_W-1:0] p,
                                         input logic [7:0] c);
        logic [39:0] txt;
        logic [2:0]  idx;
        case (k)
            KW_LOAD:  txt = KW_LOAD_TEXT;
            KW_STORE: txt = KW_STORE_TEXT;
            KW_RESET: txt = KW_RESET_TEXT;
            default:  txt = '0;
        endcase
        idx = 3'd4 - p;
        if (p >= kw_len(k))
            kw_mismatch = 1'b1;
        else
            kw_mismatch = (c != txt[{idx, 3'b000} +: 8]);
    endfunction

    // Upper-case hex digit: bit 4 is set when c is a digit, bits 3:0 its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff = c - CHAR_ZERO;
            hex_digit = {1'b1, diff[3:0]};
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            diff = c - CHAR_A + 8'd10;
            hex_digit = {1'b1, diff[3:0]};
        end
        else
        begin
            diff = '0;
            hex_digit = {1'b0, diff[3:0]};
        end
    endfunction

endpackage

`default_nettype wire

>>> design/command_token_decoder.sv
// Command token decoder: splits a zero-terminated byte stream into
// space-delimited tokens and classifies each as keyword, number or string.
// Registered: a result shows on the master side the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the master side stalls; the single output register is refilled while drained.
// Reset: rst_n clears all token state and the output valid; a zero byte rearms it too.
// Depends on ctd_pkg.
`default_nettype none

module command_token_decoder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] char_in
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] keyword_code, [17:2] number_value, [25:18] token_start,
    // [27:26] token_index, [29:28] token_count, [31:30] zero
    output logic [ctd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // [0] token_valid, [2:1] token_type
    output logic [ctd_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    output logic                                    m_axis_tlast   // message_end
);
    import ctd_pkg::*;

    // Token state.
    logic                    inside_reg,   inside_next;
    logic [TOK_CNT_W-1:0]    found_reg,    found_next;
    logic [POS_W-1:0]        pos_reg,      pos_next;
    logic [POS_W-1:0]        start_reg,    start_next;
    logic [CHAR_CNT_W-1:0]   chars_reg,    chars_next;
    logic [NUM_KW-1:0]       kw_flags_reg, kw_flags_next;
    logic                    hex_ok_reg,   hex_ok_next;
    logic [HEX_W-1:0]        hex_acc_reg,  hex_acc_next;
    logic                    ignore_reg,   ignore_next;

    // Output register.
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0]  out_user_reg, out_user_next;
    logic                    out_last_reg, out_last_next;

    logic                    accept;
    logic                    is_end;
    logic                    is_space;
    logic                    close_now;
    logic                    emit;
    logic [TOK_CNT_W-1:0]    found_inc;

    // Running token values, or their start values when a new token opens on this byte.
    logic [NUM_KW-1:0]       eff_flags;
    logic [CHAR_CNT_W-1:0]   eff_chars;
    logic                    eff_hex_ok;
    logic [HEX_W-1:0]        eff_acc;
    logic [POS_W-1:0]        eff_start;

    logic [NUM_KW-1:0]       abs_flags;
    logic [CHAR_CNT_W-1:0]   abs_chars;
    logic                    abs_hex_ok;
    logic [HEX_W-1:0]        abs_acc;
    logic [4:0]              digit;

    token_type_t             close_type;
    kw_code_t                close_code;
    logic [HEX_W-1:0]        close_value;

    token_type_t             res_type;
    kw_code_t                res_code;
    logic [HEX_W-1:0]        res_value;
    logic [7:0]              res_start;
    logic [1:0]              res_index;
    logic [1:0]              res_count;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_end        = (s_axis_tdata == CHAR_END);
    assign is_space      = (s_axis_tdata == CHAR_SPACE);
    assign close_now     = inside_reg && (is_end || (!ignore_reg && is_space));
    assign emit          = is_end || close_now;
    assign found_inc     = found_reg + 1'b1;

    assign eff_flags  = inside_reg ? kw_flags_reg : '1;
    assign eff_chars  = inside_reg ? chars_reg    : '0;
    assign eff_hex_ok = inside_reg ? hex_ok_reg   : 1'b1;
    assign eff_acc    = inside_reg ? hex_acc_reg  : '0;
    assign eff_start  = inside_reg ? start_reg    : pos_reg;

    // Fold one character into the running keyword and hex match.
    always_comb
    begin
        abs_flags  = eff_flags;
        abs_hex_ok = eff_hex_ok;
        abs_acc    = eff_acc;
        digit      = hex_digit(s_axis_tdata);
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kw_mismatch(kw_code_t'(k), eff_chars, s_axis_tdata))
                abs_flags[k] = 1'b0;
        end
        if (eff_chars == 3'd0)
        begin
            if (s_axis_tdata != CHAR_ZERO)
                abs_hex_ok = 1'b0;
        end
        else if (eff_chars == 3'd1)
        begin
            if (s_axis_tdata != CHAR_X)
                abs_hex_ok = 1'b0;
        end
        else if (eff_chars <= 3'd5)
        begin
            if (!digit[4])
                abs_hex_ok = 1'b0;
            abs_acc = {eff_acc[HEX_W-5:0], digit[3:0]};
        end
        else
        begin
            abs_hex_ok = 1'b0;
        end
        abs_chars = (eff_chars == 3'd7) ? eff_chars : eff_chars + 1'b1;
    end

    // Classify the token that is open now.
    always_comb
    begin
        close_type  = TOK_STRING;
        close_code  = KW_LOAD;
        close_value = '0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kw_flags_reg[k] && chars_reg == kw_len(kw_code_t'(k)))
            begin
                close_type = TOK_KEYWORD;
                close_code = kw_code_t'(k);
            end
        end
        if (close_type != TOK_KEYWORD && hex_ok_reg && chars_reg >= 3'd3)
        begin
            close_type  = TOK_NUMBER;
            close_value = hex_acc_reg;
        end
    end

    // State update for one accepted byte.
    always_comb
    begin
        inside_next   = inside_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        chars_next    = chars_reg;
        kw_flags_next = kw_flags_reg;
        hex_ok_next   = hex_ok_reg;
        hex_acc_next  = hex_acc_reg;
        ignore_next   = ignore_reg;
        if (accept)
        begin
            if (is_end)
            begin
                inside_next   = 1'b0;
                found_next    = '0;
                pos_next      = '0;
                start_next    = '0;
                chars_next    = '0;
                kw_flags_next = '1;
                hex_ok_next   = 1'b1;
                hex_acc_next  = '0;
                ignore_next   = 1'b0;
            end
            else
            begin
                if (!ignore_reg)
                begin
                    if (is_space)
                    begin
                        if (inside_reg)
                        begin
                            inside_next = 1'b0;
                            found_next  = found_inc;
                            if (int'(found_inc) >= MAX_TOKENS)
                                ignore_next = 1'b1;
                        end
                    end
                    else
                    begin
                        inside_next   = 1'b1;
                        start_next    = eff_start;
                        chars_next    = abs_chars;
                        kw_flags_next = abs_flags;
                        hex_ok_next   = abs_hex_ok;
                        hex_acc_next  = abs_acc;
                    end
                end
                if (pos_reg == POS_W'(MSG_LENGTH - 1))
                    pos_next = '0;
                else
                    pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Result fields; token fields read zero when no token closes.
    always_comb
    begin
        res_type  = close_now ? close_type  : TOK_KEYWORD;
        res_code  = (close_now && close_type == TOK_KEYWORD) ? close_code : KW_LOAD;
        res_value = close_now ? close_value : '0;
        res_start = close_now ? 8'(start_reg) : 8'd0;
        res_index = close_now ? 2'(found_reg) : 2'd0;
        if (is_end)
            res_count = close_now ? 2'(found_inc) : 2'(found_reg);
        else
            res_count = 2'd0;
        out_data_next = {2'b00, res_count, res_index, res_start, res_value, res_code};
        out_user_next = {res_type, close_now};
        out_last_next = is_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            found_reg     <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            chars_reg     <= '0;
            kw_flags_reg  <= '1;
            hex_ok_reg    <= 1'b1;
            hex_acc_reg   <= '0;
            ignore_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inside_reg    <= inside_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            chars_reg     <= chars_next;
            kw_flags_reg  <= kw_flags_next;
            hex_ok_reg    <= hex_ok_next;
            hex_acc_reg   <= hex_acc_next;
            ignore_reg    <= ignore_next;
            if (s_axis_tready)
                out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A result that does not end the message must close a token.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0])
        else $error("result without token or message end");

    // The token count is only reported with the end of a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[29:28] == 2'd0)
        else $error("token count outside message end");

    // Bytes are ignored only once the token limit has been reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        ignore_reg |-> int'(found_reg) == MAX_TOKENS && !inside_reg)
        else $error("ignoring bytes below the token limit");

    // A zero byte rearms the decoder on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_end |=> !inside_reg && found_reg == '0 && pos_reg == '0)
        else $error("decoder not rearmed after message end");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for command_token_decoder: byte stream in, token results out.
// A tokenizer model predicts each result and a monitor compares every output transaction.
// Depends on ctd_pkg and the command_token_decoder RTL.
`timescale 1ns / 1ps

module tb;

    import ctd_pkg::*;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_BYTES = 430;
    localparam int         MAX_REPORTS  = 10;

    typedef struct packed {
        logic        token_valid;
        token_type_t token_type;
        kw_code_t    keyword_code;
        logic [15:0] number_value;
        logic [7:0]  token_start;
        logic [1:0]  token_index;
        logic        message_end;
        logic [1:0]  token_count;
    } token_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // [1:0] keyword_code, [17:2] number_value, [25:18] token_start,
                                 // [27:26] token_index, [29:28] token_count, [31:30] zero
    logic [2:0]  m_axis_tuser;   // [0] token_valid, [2:1] token_type
    logic        m_axis_tlast;   // message_end

    // Tokenizer state mirrored by the predictor.
    bit          in_token;
    int          tok_found;
    logic [7:0]  byte_pos;
    logic [7:0]  tok_start;
    int          tok_len;
    logic [2:0]  kw_alive;
    bit          hex_ok;
    logic [15:0] hex_acc;
    bit          skip_rest;

    string kw_spell [3] = '{"load", "store", "reset"};
    string hex_chars = "0123456789ABCDEF";
    string bad_chars = "aGfg:/@X";

    token_result_t pending_tokens [$];
    token_result_t seen;
    token_result_t want;

    bit steady;
    int errors;
    int cycle_count;
    int bytes_sent;
    int messages_sent;
    int results_checked;
    int kind_count [3];

    command_token_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_state();
        in_token  = 1'b0;
        tok_found = 0;
        byte_pos  = '0;
        tok_start = '0;
        tok_len   = 0;
        kw_alive  = 3'b111;
        hex_ok    = 1'b1;
        hex_acc   = '0;
        skip_rest = 1'b0;
    endfunction

    function automatic token_result_t close_token();
        token_result_t r;
        int            k;
        r = '0;
        r.token_valid = 1'b1;
        r.token_type  = TOK_STRING;
        for (k = 0; k < 3; k++)
        begin
            if (kw_alive[k] && tok_len == kw_spell[k].len())
            begin
                r.token_type   = TOK_KEYWORD;
                r.keyword_code = kw_code_t'(k);
            end
        end
        // "0x" plus at least one digit, and no keyword took precedence.
        if (r.token_type != TOK_KEYWORD && hex_ok && tok_len >= 3)
        begin
            r.token_type   = TOK_NUMBER;
            r.number_value = hex_acc;
        end
        r.token_start = tok_start;
        r.token_index = 2'(tok_found);
        in_token = 1'b0;
        tok_found++;
        if (tok_found >= MAX_TOKENS)
            skip_rest = 1'b1;
        return r;
    endfunction

    // Advances the tokenizer by one byte; returns 1 when the byte yields a result.
    function automatic bit decode_char(input logic [7:0] c, output token_result_t r);
        logic [3:0] d;
        int         p;
        int         k;
        r = '0;
        if (c == CH_END)
        begin
            if (in_token)
                r = close_token();
            r.message_end = 1'b1;
            r.token_count = 2'(tok_found);
            clear_state();
            return 1'b1;
        end
        if (!skip_rest)
        begin
            if (c == CH_SPACE)
            begin
                if (in_token)
                    r = close_token();
            end
            else
            begin
                if (!in_token)
                begin
                    in_token  = 1'b1;
                    tok_start = byte_pos;
                    tok_len   = 0;
                    kw_alive  = 3'b111;
                    hex_ok    = 1'b1;
                    hex_acc   = '0;
                end
                p = tok_len;
                for (k = 0; k < 3; k++)
                begin
                    if (p >= kw_spell[k].len() || c != 8'(kw_spell[k][p]))
                        kw_alive[k] = 1'b0;
                end
                if (p == 0)
                begin
                    if (c != "0")
                        hex_ok = 1'b0;
                end
                else if (p == 1)
                begin
                    if (c != "x")
                        hex_ok = 1'b0;
                end
                else if (p <= 5)
                begin
                    d = '0;
                    if (c >= "0" && c <= "9")
                        d = 4'(c - "0");
                    else if (c >= "A" && c <= "F")
                        d = 4'(c - "A" + 8'd10);
                    else
                        hex_ok = 1'b0;
                    hex_acc = {hex_acc[11:0], d};
                end
                else
                    hex_ok = 1'b0;
                if (tok_len < 7)
                    tok_len++;
            end
        end
        byte_pos++;
        return r.token_valid;
    endfunction

    // Sends one byte, with an occasional idle gap before it.
    task automatic send_char(input logic [7:0] c);
        int            gap;
        token_result_t r;
        gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 2) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        if (decode_char(c, r))
            pending_tokens.push_back(r);
    endtask

    task automatic send_bytes(input logic [7:0] m [$]);
        foreach (m[i])
            send_char(m[i]);
        messages_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] m [$];
        foreach (s[i])
            m.push_back(8'(s[i]));
        m.push_back(CH_END);
        send_bytes(m);
    endtask

    function automatic void add_token(ref logic [7:0] m [$]);
        int    n;
        int    i;
        int    w;
        string s;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                // Keyword, sometimes cut short or overextended.
                s = kw_spell[$urandom_range(0, 2)];
                w = $urandom_range(0, 4);
                n = (w == 0) ? s.len() - 1 : (w == 1) ? s.len() + 1 : s.len();
                for (i = 0; i < n; i++)
                    m.push_back(i < s.len() ? 8'(s[i]) : "s");
            end
            3, 4, 5:
            begin
                n = $urandom_range(1, 5);
                m.push_back("0");
                m.push_back(($urandom_range(0, 9) == 0) ? "X" : "x");
                for (i = 0; i < n; i++)
                    m.push_back(8'(hex_chars[$urandom_range(0, 15)]));
                if ($urandom_range(0, 5) == 0)
                    m[m.size() - 1 - $urandom_range(0, n - 1)] =
                        8'(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
            end
            6, 7:
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                begin
                    w = $urandom_range(1, 254);
                    m.push_back(w >= 32 ? 8'(w + 1) : 8'(w));
                end
            end
            8:
            begin
                n = $urandom_range(7, 12);
                for (i = 0; i < n; i++)
                    m.push_back(8'($urandom_range("a", "z")));
            end
            default:
            begin
                m.push_back("0");
                if ($urandom_range(0, 1) == 1)
                    m.push_back("x");
            end
        endcase
    endfunction

    function automatic void build_message(ref logic [7:0] m [$]);
        int ntok;
        int i;
        m.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // Raw noise, including the odd early terminator.
            ntok = $urandom_range(1, 20);
            for (i = 0; i < ntok; i++)
                m.push_back(8'($urandom_range(0, 39) == 0 ? 0 : $urandom_range(1, 255)));
        end
        else
        begin
            ntok = $urandom_range(0, 5);
            repeat ($urandom_range(0, 2)) m.push_back(CH_SPACE);
            for (i = 0; i < ntok; i++)
            begin
                add_token(m);
                repeat (i == ntok - 1 ? $urandom_range(0, 2) : $urandom_range(1, 3))
                    m.push_back(CH_SPACE);
            end
        end
        m.push_back(CH_END);
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                         name, results_checked, exp_v, act_v);
        end
    endfunction

    always @(negedge clk)
        m_axis_tready = steady ? 1'b1 : ($urandom_range(0, 99) >= 30);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.token_valid  = m_axis_tuser[0];
            seen.token_type   = token_type_t'(m_axis_tuser[2:1]);
            seen.keyword_code = kw_code_t'(m_axis_tdata[1:0]);
            seen.number_value = m_axis_tdata[17:2];
            seen.token_start  = m_axis_tdata[25:18];
            seen.token_index  = m_axis_tdata[27:26];
            seen.token_count  = m_axis_tdata[29:28];
            seen.message_end  = m_axis_tlast;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: tdata 0x%h tuser 0x%h tlast %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_valid",  want.token_valid,  seen.token_valid);
                check_field("token_type",   want.token_type,   seen.token_type);
                check_field("keyword_code", want.keyword_code, seen.keyword_code);
                check_field("number_value", want.number_value, seen.number_value);
                check_field("token_start",  want.token_start,  seen.token_start);
                check_field("token_index",  want.token_index,  seen.token_index);
                check_field("message_end",  want.message_end,  seen.message_end);
                check_field("token_count",  want.token_count,  seen.token_count);
                if (want.token_valid)
                    kind_count[want.token_type]++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_tokens.size());
            $display("FAIL command_token_decoder");
            $finish;
        end
    end

    task automatic test_empty_message();
        send_text("");
    endtask

    task automatic test_keywords_and_numbers();
        send_text("load 0x0");
        send_text("store  reset 0xFFFF");
    endtask

    // The fourth token and everything after it must be dropped.
    task automatic test_token_limit();
        send_text("reset \377ab 0x1 store q");
    endtask

    // Tokens on either side of the position counter's wrap point.
    task automatic test_position_wrap();
        logic [7:0] m [$];
        string      s;
        s = "ab cd";
        repeat (253) m.push_back(CH_SPACE);
        foreach (s[i])
            m.push_back(8'(s[i]));
        m.push_back(CH_END);
        send_bytes(m);
    endtask

    task automatic test_random_messages();
        logic [7:0] m [$];
        int         start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // A stretch in the middle runs with no idle cycles on either side.
            steady = (bytes_sent - start > 150 && bytes_sent - start < 300);
            build_message(m);
            send_bytes(m);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clear_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_message();
        test_keywords_and_numbers();
        test_token_limit();
        test_position_wrap();
        test_random_messages();

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d bytes in %0d messages; %0d results checked.",
                 bytes_sent, messages_sent, results_checked);
        $display("Tokens seen: %0d keywords, %0d numbers, %0d strings.",
                 kind_count[TOK_KEYWORD], kind_count[TOK_NUMBER], kind_count[TOK_STRING]);
        if (errors == 0)
            $display("PASS command_token_decoder");
        else
            $display("FAIL command_token_decoder");
        $finish;
    end

endmodule

>>> files.f
design/ctd_pkg.sv
design/command_token_decoder.sv
verif/tb.sv
